FILE: src/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

FILE: src/rau_pkg.sv
`default_nettype none
package rau_pkg;

    localparam logic [2:0] MODE_ADD = 3'd0;
    localparam logic [2:0] MODE_SUB = 3'd1;
    localparam logic [2:0] MODE_MUL = 3'd2;
    localparam logic [2:0] MODE_DIV = 3'd3;
    localparam logic [2:0] MODE_RED = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef struct packed {
        logic less;
        logic equal;
        logic greater;
    } t_flags;

endpackage
`default_nettype wire

FILE: src/rau_front.sv
`default_nettype none
module rau_front #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic [2:0]                           i_mode,
    input  wire logic signed [31:0]                   i_a_num,
    input  wire logic signed [31:0]                   i_a_den,
    input  wire logic signed [31:0]                   i_b_num,
    input  wire logic signed [31:0]                   i_b_den,
    output logic                                      o_push,
    input  wire logic                                 i_full,
    output logic [4*OPERAND_WIDTH+4:0]                o_data
);
    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * OPERAND_WIDTH;

    typedef enum logic [5:0] {
        F_IDLE = 6'b000001,
        F_M1   = 6'b000010,
        F_M2   = 6'b000100,
        F_M3   = 6'b001000,
        F_M4   = 6'b010000,
        F_PUSH = 6'b100000
    } t_fstate;

    function automatic logic [PW:0] sadd(input logic xn, input logic [PW-1:0] xm,
                                         input logic yn, input logic [PW-1:0] ym);
        logic          rn;
        logic [PW-1:0] rm;
        if (xn == yn) begin
            rm = xm + ym;
            rn = xn;
        end else if (xm >= ym) begin
            rm = xm - ym;
            rn = xn;
        end else begin
            rm = ym - xm;
            rn = yn;
        end
        return {rn && (rm != '0), rm};
    endfunction

    t_fstate r_state, n_state;
    logic [2:0]    r_mode;
    logic          r_an_neg, r_bn_neg;
    logic [W-1:0]  r_an_mag, r_ad_mag, r_bn_mag, r_bd_mag;
    logic [PW-1:0] r_p1, r_p2, r_p3, r_p4;

    logic [W-1:0]  an_v, ad_v, bn_v, bd_v;
    logic [W-1:0]  an_m, ad_m, bn_m, bd_m;
    logic [W-1:0]  mul_x, mul_y;
    logic [PW-1:0] product;
    logic          accept;
    logic          p1_neg, p2_neg, p2_negated;
    logic          is_red, err;
    rau_pkg::t_flags flags;
    logic          num_neg;
    logic [PW-1:0] num_mag, den_mag;
    logic [PW:0]   sum;

    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != F_IDLE);

    assign an_v = i_a_num[W-1:0];
    assign ad_v = i_a_den[W-1:0];
    assign bn_v = i_b_num[W-1:0];
    assign bd_v = i_b_den[W-1:0];
    assign an_m = an_v[W-1] ? (~an_v + 1'b1) : an_v;
    assign ad_m = ad_v[W-1] ? (~ad_v + 1'b1) : ad_v;
    assign bn_m = bn_v[W-1] ? (~bn_v + 1'b1) : bn_v;
    assign bd_m = bd_v[W-1] ? (~bd_v + 1'b1) : bd_v;

    always_comb begin
        mul_x = r_an_mag;
        mul_y = r_bd_mag;
        unique case (r_state)
            F_M2: begin
                mul_x = r_bn_mag;
                mul_y = r_ad_mag;
            end
            F_M3: begin
                mul_x = r_ad_mag;
                mul_y = (r_mode == rau_pkg::MODE_DIV) ? r_bn_mag : r_bd_mag;
            end
            F_M4: begin
                mul_x = r_an_mag;
                mul_y = r_bn_mag;
            end
            default: begin
                mul_x = r_an_mag;
                mul_y = r_bd_mag;
            end
        endcase
    end

    assign product = PW'(mul_x) * PW'(mul_y);

    always_comb begin
        p1_neg     = r_an_neg && (r_p1 != '0);
        p2_neg     = r_bn_neg && (r_p2 != '0);
        p2_negated = !r_bn_neg && (r_p2 != '0);
        is_red     = (r_mode >= rau_pkg::MODE_RED);
        err        = (r_ad_mag == '0) || (!is_red && r_bd_mag == '0) ||
                     (r_mode == rau_pkg::MODE_DIV && r_bn_mag == '0);
        flags      = '0;
        if (r_ad_mag != '0 && r_bd_mag != '0) begin
            if (p1_neg != p2_neg) begin
                flags.less    = p1_neg;
                flags.greater = !p1_neg;
            end else if (r_p1 == r_p2) begin
                flags.equal = 1'b1;
            end else if (p1_neg) begin
                flags.less    = (r_p1 > r_p2);
                flags.greater = (r_p1 < r_p2);
            end else begin
                flags.less    = (r_p1 < r_p2);
                flags.greater = (r_p1 > r_p2);
            end
        end
        sum     = '0;
        num_neg = 1'b0;
        num_mag = '0;
        den_mag = r_p3;
        unique case (r_mode)
            rau_pkg::MODE_ADD: begin
                sum     = sadd(p1_neg, r_p1, p2_neg, r_p2);
                num_neg = sum[PW];
                num_mag = sum[PW-1:0];
            end
            rau_pkg::MODE_SUB: begin
                sum     = sadd(p1_neg, r_p1, p2_negated, r_p2);
                num_neg = sum[PW];
                num_mag = sum[PW-1:0];
            end
            rau_pkg::MODE_MUL: begin
                num_neg = (r_an_neg ^ r_bn_neg) && (r_p4 != '0);
                num_mag = r_p4;
            end
            rau_pkg::MODE_DIV: begin
                num_neg = (r_an_neg ^ r_bn_neg) && (r_p1 != '0);
                num_mag = r_p1;
            end
            default: begin
                num_neg = r_an_neg;
                num_mag = PW'(r_an_mag);
                den_mag = PW'(r_ad_mag);
            end
        endcase
    end

    assign o_push = (r_state == F_PUSH) && !i_full;
    assign o_data = {err, num_neg, num_mag, den_mag, flags};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE:  if (accept) n_state = F_M1;
            F_M1:    n_state = F_M2;
            F_M2:    n_state = F_M3;
            F_M3:    n_state = F_M4;
            F_M4:    n_state = F_PUSH;
            F_PUSH:  if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode   <= i_mode;
            r_an_neg <= (an_v[W-1] ^ ad_v[W-1]) && (an_m != '0);
            r_bn_neg <= (bn_v[W-1] ^ bd_v[W-1]) && (bn_m != '0);
            r_an_mag <= an_m;
            r_ad_mag <= ad_m;
            r_bn_mag <= bn_m;
            r_bd_mag <= bd_m;
        end
        if (r_state == F_M1) r_p1 <= product;
        if (r_state == F_M2) r_p2 <= product;
        if (r_state == F_M3) r_p3 <= product;
        if (r_state == F_M4) r_p4 <= product;
    end
endmodule
`default_nettype wire

FILE: src/rau_queue.sv
`default_nettype none
`include "assert_macros.svh"
module rau_queue #(
    parameter int DATA_W = 133
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic [DATA_W-1:0]      o_data,
    output logic                   o_empty
);
    logic [DATA_W-1:0] r_mem [2];
    logic              r_wr_ptr, r_rd_ptr;
    logic [1:0]        r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= !r_wr_ptr;
            if (i_pop) r_rd_ptr <= !r_rd_ptr;
            if (i_push && !i_pop) r_count <= r_count + 2'd1;
            else if (i_pop && !i_push) r_count <= r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full)
    `ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && o_empty)
    `ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_count == 2'd3)
endmodule
`default_nettype wire

FILE: src/rau_back.sv
`default_nettype none
`include "assert_macros.svh"
module rau_back #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_empty,
    input  wire logic [4*OPERAND_WIDTH+4:0]    i_data,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed [31:0]                 o_res_num,
    output logic [30:0]                        o_res_den,
    output logic [1:0]                         o_status,
    output logic                               o_a_less,
    output logic                               o_a_equal,
    output logic                               o_a_greater
);
    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * OPERAND_WIDTH;
    localparam int KW = $clog2(PW) + 1;
    localparam int CW = $clog2(PW);
    localparam logic [PW-1:0] HALF = PW'(1) << (W - 1);

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_GCD  = 5'b00010,
        B_DIVN = 5'b00100,
        B_DIVD = 5'b01000,
        B_DONE = 5'b10000
    } t_bstate;

    t_bstate r_state;
    logic            r_neg;
    logic [PW-1:0]   r_num, r_den, r_u, r_v, r_g, r_rem, r_quo, r_m, r_d;
    logic [KW-1:0]   r_k;
    logic [CW-1:0]   r_cnt;
    logic [1:0]      r_sts;
    rau_pkg::t_flags r_flags;
    logic            r_ovalid;

    logic            q_err, q_neg;
    logic [PW-1:0]   q_num, q_den;
    rau_pkg::t_flags q_flags;
    logic [PW:0]     rem_sh;
    logic            q_bit;
    logic [PW-1:0]   rem_nx, quo_nx;
    logic            fits, out_free, div_last;

    assign {q_err, q_neg, q_num, q_den, q_flags} = i_data;
    assign o_pop    = (r_state == B_IDLE) && !i_empty;
    assign out_free = !r_ovalid || !i_stall;
    assign div_last = (r_cnt == CW'(PW - 1));

    assign rem_sh = {r_rem, r_quo[PW-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_g});
    assign rem_nx = q_bit ? PW'(rem_sh - {1'b0, r_g}) : rem_sh[PW-1:0];
    assign quo_nx = {r_quo[PW-2:0], q_bit};

    assign fits = (r_d <= HALF - PW'(1)) && (r_neg ? (r_m <= HALF) : (r_m <= HALF - PW'(1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == B_DONE && out_free) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        if (q_err || q_num == '0) r_state <= B_DONE;
                        else r_state <= B_GCD;
                    end
                end
                B_GCD:  if (r_u == '0) r_state <= B_DIVN;
                B_DIVN: if (div_last) r_state <= B_DIVD;
                B_DIVD: if (div_last) r_state <= B_DONE;
                B_DONE: begin
                    if (out_free) r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                r_neg   <= q_neg;
                r_num   <= q_num;
                r_den   <= q_den;
                r_u     <= q_num;
                r_v     <= q_den;
                r_k     <= '0;
                r_flags <= q_flags;
                r_sts   <= q_err ? rau_pkg::ST_ZERO : rau_pkg::ST_OK;
                r_m     <= '0;
                r_d     <= PW'(1);
            end
            B_GCD: begin
                if (r_u == '0) begin
                    r_g   <= r_v << r_k;
                    r_rem <= '0;
                    r_quo <= r_num;
                    r_cnt <= '0;
                end else if (!r_u[0] && !r_v[0]) begin
                    r_u <= r_u >> 1;
                    r_v <= r_v >> 1;
                    r_k <= r_k + KW'(1);
                end else if (!r_u[0]) begin
                    r_u <= r_u >> 1;
                end else if (!r_v[0]) begin
                    r_v <= r_v >> 1;
                end else if (r_u >= r_v) begin
                    r_u <= r_u - r_v;
                end else begin
                    r_v <= r_v - r_u;
                end
            end
            B_DIVN: begin
                r_cnt <= r_cnt + CW'(1);
                r_rem <= rem_nx;
                r_quo <= quo_nx;
                if (div_last) begin
                    r_m   <= quo_nx;
                    r_rem <= '0;
                    r_quo <= r_den;
                    r_cnt <= '0;
                end
            end
            B_DIVD: begin
                r_cnt <= r_cnt + CW'(1);
                r_rem <= rem_nx;
                r_quo <= quo_nx;
                if (div_last) r_d <= quo_nx;
            end
            B_DONE: begin
                if (out_free) begin
                    o_a_less    <= r_flags.less;
                    o_a_equal   <= r_flags.equal;
                    o_a_greater <= r_flags.greater;
                    if (r_sts != rau_pkg::ST_OK || !fits || r_m == '0) begin
                        o_res_num <= '0;
                        o_res_den <= 31'd1;
                        o_status  <= (r_sts != rau_pkg::ST_OK) ? r_sts :
                                     (fits ? rau_pkg::ST_OK : rau_pkg::ST_OVF);
                    end else begin
                        o_res_num <= r_neg ? -$signed(32'(r_m)) : $signed(32'(r_m));
                        o_res_den <= 31'(r_d);
                        o_status  <= rau_pkg::ST_OK;
                    end
                end
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

    assign o_valid = r_ovalid;

    `ASSERT_CLK(a_den_positive, i_clk, i_rst_n, o_valid |-> o_res_den != 31'd0)
    `ASSERT_CLK(a_err_zero, i_clk, i_rst_n,
        (o_valid && o_status != rau_pkg::ST_OK) |-> (o_res_num == 32'sd0 && o_res_den == 31'd1))
    `ASSERT_CLK(a_gcd_v_nonzero, i_clk, i_rst_n, (r_state == B_GCD) |-> r_v != '0)
endmodule
`default_nettype wire

FILE: src/rational_arithmetic_unit_core.sv
// exact arithmetic on two fractions with gcd reduction
// input channel: i_valid / o_stall carries mode, a_num, a_den, b_num, b_den;
// a transaction is taken on a rising edge with i_valid high and o_stall low
// output channel: o_valid / i_stall carries the reduced fraction, status and
// the three comparison flags of a against b, one result per transaction
// the front stage forms the four cross products on one shared multiplier in
// states F_M1 to F_M4 and hands a classified transaction to a two-entry queue
// from F_PUSH once the queue is not full; the back stage runs a binary gcd
// (one step per cycle) and two restoring divisions, of the numerator and of
// the denominator by the gcd; errors and zero numerators skip the gcd and
// divisions and go straight to the output register; throughput is one
// transaction per back stage run
// the front takes a new transaction while the back is busy, and the back
// starts its next one while a finished result waits in the output register
// a stalled result holds its payload until taken
// synchronous active-low reset empties the queue and drops o_valid
`default_nettype none
module rational_arithmetic_unit_core #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [2:0]         i_mode,
    input  wire logic signed [31:0] i_a_num,
    input  wire logic signed [31:0] i_a_den,
    input  wire logic signed [31:0] i_b_num,
    input  wire logic signed [31:0] i_b_den,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_res_num,
    output logic [30:0]             o_res_den,
    output logic [1:0]              o_status,
    output logic                    o_a_less,
    output logic                    o_a_equal,
    output logic                    o_a_greater
);
    localparam int QW = 4 * OPERAND_WIDTH + 5;

    logic          push, pop, full, empty;
    logic [QW-1:0] push_data, pop_data;

    rau_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_mode  (i_mode),
        .i_a_num (i_a_num),
        .i_a_den (i_a_den),
        .i_b_num (i_b_num),
        .i_b_den (i_b_den),
        .o_push  (push),
        .i_full  (full),
        .o_data  (push_data)
    );

    rau_queue #(.DATA_W(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (pop_data),
        .o_empty (empty)
    );

    rau_back #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_data      (pop_data),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_res_num   (o_res_num),
        .o_res_den   (o_res_den),
        .o_status    (o_status),
        .o_a_less    (o_a_less),
        .o_a_equal   (o_a_equal),
        .o_a_greater (o_a_greater)
    );
endmodule
`default_nettype wire
